### rtl/core/xxtea_block_cipher_top_macros.svh
// Assertion helpers for the cipher block. Both sample on clk_i and stay
// quiet while rst_ni is low.
`ifndef XXTEA_BLOCK_CIPHER_TOP_MACROS_SVH
`define XXTEA_BLOCK_CIPHER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xxtea assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define XX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xxtea assertion failed");

`endif

### rtl/core/xxtea_pkg.sv
package xxtea_pkg;

  localparam logic [31:0] TEA_DELTA = 32'h9e3779b9;

  localparam int unsigned ROUNDS_W    = 6;
  localparam int unsigned ROUNDS_BASE = 6;
  localparam int unsigned NW_FN       = 11;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd4;

  typedef struct packed {
    logic        decrypt;
    logic [31:0] sum;
    logic [31:0] key;
  } mix_ctrl_t;

  // 52 / n for a block length n of at least one word
  function automatic logic [ROUNDS_W-1:0] rounds_extra(input logic [NW_FN-1:0] n);
    logic [ROUNDS_W-1:0] r;
    priority if (n == 11'd1) r = 6'd52;
    else if (n == 11'd2)     r = 6'd26;
    else if (n == 11'd3)     r = 6'd17;
    else if (n == 11'd4)     r = 6'd13;
    else if (n == 11'd5)     r = 6'd10;
    else if (n == 11'd6)     r = 6'd8;
    else if (n == 11'd7)     r = 6'd7;
    else if (n == 11'd8)     r = 6'd6;
    else if (n <= 11'd10)    r = 6'd5;
    else if (n <= 11'd13)    r = 6'd4;
    else if (n <= 11'd17)    r = 6'd3;
    else if (n <= 11'd26)    r = 6'd2;
    else if (n <= 11'd52)    r = 6'd1;
    else                     r = 6'd0;
    return r;
  endfunction

endpackage

### rtl/core/xxtea_if.sv
interface xxtea_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] in_word;
  logic        in_last;

  modport source (output valid, output in_word, output in_last, input ready);
  modport sink   (input valid, input in_word, input in_last, output ready);
endinterface

interface xxtea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        out_last;
  logic        overflow;

  modport source (output valid, output out_word, output out_last, output overflow,
                  input ready);
  modport sink   (input valid, input out_word, input out_last, input overflow,
                  output ready);
endinterface

interface xxtea_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [xxtea_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/xxtea_mix.sv
module xxtea_mix (
  input  xxtea_pkg::mix_ctrl_t ctrl_i,
  input  logic [31:0]          cur_i,
  input  logic [31:0]          carry_i,
  input  logic [31:0]          nb_i,
  output logic [31:0]          word_o
);

  logic [31:0] z;
  logic [31:0] y;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] m;

  // encryption carries z forward and reads y ahead; decryption the reverse
  assign z = ctrl_i.decrypt ? nb_i : carry_i;
  assign y = ctrl_i.decrypt ? carry_i : nb_i;

  assign a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
  assign b = (ctrl_i.sum ^ y) + (ctrl_i.key ^ z);
  assign m = a ^ b;

  assign word_o = ctrl_i.decrypt ? (cur_i - m) : (cur_i + m);

endmodule

### rtl/core/xxtea_block_cipher_top.sv
// XXTEA block cipher, one 32-bit word per transaction.
// in_chan takes the words of a block in order, in_last on the final one.
// cfg_chan writes key words 0..3 and the decrypt mode (index 4); write it
// only while no block is in flight. cfg_chan is always ready.
// Each input transaction yields at most one result on out_chan: the next
// word of the most recently processed block, if any remains.
// A word that is not last is taken in ST_IDLE; when it releases a queued
// result, the memory read comes first, then the output register load.
// A last word runs rounds * n mixing steps, rounds = 6 + 52 / n: one mixing
// step per cycle, paced by the single read port of the block memory, after
// three prefetch reads and before the read of word 0.
// Blocks live in two banks of one memory: the next block loads into one
// bank while the other drains. Words beyond MAX_WORDS are dropped and the
// block's results carry overflow.
// A stalled receiver holds the output register; one more input may be
// accepted, and its result waits until the register frees up.
// Reset empties the queue, clears the word count and zeroes the key and mode.
`include "xxtea_block_cipher_top_macros.svh"

module xxtea_block_cipher_top #(
  parameter int unsigned MAX_WORDS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  xxtea_in_if.sink     in_chan,
  xxtea_out_if.source  out_chan,
  xxtea_cfg_if.sink    cfg_chan
);

  import xxtea_pkg::*;

  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_OUT  = 7'b0000010,
    ST_PRE0 = 7'b0000100,
    ST_PRE1 = 7'b0001000,
    ST_PRE2 = 7'b0010000,
    ST_RUN  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] key_q [4];
  logic [31:0] key_d [4];
  logic        mode_q, mode_d;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] n_q, n_d;
  logic          block_ovf_q, block_ovf_d;
  logic          ld_bank_q, ld_bank_d;
  logic          q_bank_q, q_bank_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          qovf_q, qovf_d;
  logic [ROUNDS_W-1:0] rounds_q, rounds_d;
  logic          fwd_q, fwd_d;
  logic          out_valid_q, out_valid_d;

  logic [31:0]   sum_q, sum_d;
  logic [31:0]   carry_q, carry_d;
  logic [31:0]   cur_q, cur_d;
  logic [AW-1:0] p_q, p_d;
  logic [31:0]   fwd_data_q, fwd_data_d;
  logic [31:0]   out_word_q, out_word_d;
  logic          out_last_q, out_last_d;
  logic          out_ovf_q, out_ovf_d;

  logic [31:0]   mem [0:(2 << AW) - 1];
  logic [31:0]   rdata_q;
  logic          we;
  logic [AW:0]   waddr;
  logic [31:0]   wdata;
  logic          re;
  logic [AW:0]   raddr;

  logic [AW-1:0] n_m1;
  logic          n_one;
  logic [AW-1:0] p_next;
  logic [AW-1:0] p_next2;
  logic          round_end;
  logic [31:0]   nb;
  logic [31:0]   new_word;
  logic [1:0]    ksel;
  mix_ctrl_t     mix_ctrl;
  logic          load;
  logic          out_free;

  function automatic logic [AW-1:0] idx_fwd(input logic [AW-1:0] x,
                                            input logic [AW-1:0] top);
    return (x == top) ? '0 : AW'(x + 1'b1);
  endfunction

  function automatic logic [AW-1:0] idx_bwd(input logic [AW-1:0] x,
                                            input logic [AW-1:0] top);
    return (x == '0) ? top : AW'(x - 1'b1);
  endfunction

  assign n_m1  = AW'(n_q - 1'b1);
  assign n_one = (n_q == CW'(1));

  assign p_next    = mode_q ? idx_bwd(p_q, n_m1) : idx_fwd(p_q, n_m1);
  assign p_next2   = mode_q ? idx_bwd(p_next, n_m1) : idx_fwd(p_next, n_m1);
  assign round_end = mode_q ? (p_q == '0) : (p_q == n_m1);

  assign nb   = fwd_q ? fwd_data_q : rdata_q;
  assign ksel = 2'(p_q) ^ sum_q[3:2];

  assign mix_ctrl.decrypt = mode_q;
  assign mix_ctrl.sum     = sum_q;
  assign mix_ctrl.key     = key_q[ksel];

  xxtea_mix u_mix (
    .ctrl_i  (mix_ctrl),
    .cur_i   (cur_q),
    .carry_i (carry_q),
    .nb_i    (nb),
    .word_o  (new_word)
  );

  assign load     = (count_q < CW'(MAX_WORDS));
  assign out_free = !out_valid_q || out_chan.ready;

  assign in_chan.ready     = (state_q == ST_IDLE);
  assign cfg_chan.ready    = 1'b1;
  assign out_chan.valid    = out_valid_q;
  assign out_chan.out_word = out_word_q;
  assign out_chan.out_last = out_last_q;
  assign out_chan.overflow = out_ovf_q;

  always_comb begin
    key_d  = key_q;
    mode_d = mode_q;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_KEY_0: key_d[0] = cfg_chan.data;
        REG_KEY_1: key_d[1] = cfg_chan.data;
        REG_KEY_2: key_d[2] = cfg_chan.data;
        REG_KEY_3: key_d[3] = cfg_chan.data;
        REG_MODE:  mode_d   = cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    block_ovf_d = block_ovf_q;
    ld_bank_d   = ld_bank_q;
    q_bank_d    = q_bank_q;
    len_d       = len_q;
    pos_d       = pos_q;
    qovf_d      = qovf_q;
    rounds_d    = rounds_q;
    fwd_d       = fwd_q;
    sum_d       = sum_q;
    carry_d     = carry_q;
    cur_d       = cur_q;
    p_d         = p_q;
    fwd_data_d  = fwd_data_q;
    out_word_d  = out_word_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q && !out_chan.ready;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    re          = 1'b0;
    raddr       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_chan.valid) begin
          if (load) begin
            we      = 1'b1;
            waddr   = {ld_bank_q, count_q[AW-1:0]};
            wdata   = in_chan.in_word;
            count_d = CW'(count_q + 1'b1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_chan.in_last) begin
            n_d         = load ? CW'(count_q + 1'b1) : count_q;
            block_ovf_d = ovf_q || !load;
            count_d     = '0;
            ovf_d       = 1'b0;
            state_d     = ST_PRE0;
          end else if (pos_q < len_q) begin
            re      = 1'b1;
            raddr   = {q_bank_q, pos_q[AW-1:0]};
            state_d = ST_OUT;
          end
        end
      end

      ST_OUT: begin
        // hold the read data until the output register frees up
        if (out_free) begin
          out_word_d  = rdata_q;
          out_last_d  = (CW'(pos_q + 1'b1) == len_q);
          out_ovf_d   = qovf_q;
          out_valid_d = 1'b1;
          pos_d       = CW'(pos_q + 1'b1);
          state_d     = ST_IDLE;
        end
      end

      ST_PRE0: begin
        rounds_d = ROUNDS_W'(ROUNDS_BASE) + rounds_extra(NW_FN'(n_q));
        re       = 1'b1;
        raddr    = {ld_bank_q, (mode_q ? AW'(0) : n_m1)};
        state_d  = ST_PRE1;
      end

      ST_PRE1: begin
        carry_d = rdata_q;
        sum_d   = mode_q ? 32'({26'd0, rounds_q} * TEA_DELTA) : TEA_DELTA;
        p_d     = mode_q ? n_m1 : '0;
        re      = 1'b1;
        raddr   = {ld_bank_q, (mode_q ? n_m1 : AW'(0))};
        state_d = ST_PRE2;
      end

      ST_PRE2: begin
        cur_d   = rdata_q;
        fwd_d   = 1'b0;
        re      = 1'b1;
        raddr   = {ld_bank_q, p_next};
        state_d = ST_RUN;
      end

      ST_RUN: begin
        we    = 1'b1;
        waddr = {ld_bank_q, p_q};
        wdata = new_word;
        // prefetch the neighbor of the following step; forward on a clash
        re         = 1'b1;
        raddr      = {ld_bank_q, p_next2};
        fwd_d      = (p_next2 == p_q);
        fwd_data_d = new_word;
        carry_d    = new_word;
        cur_d      = n_one ? new_word : nb;
        p_d        = p_next;
        if (round_end) begin
          if (rounds_q == ROUNDS_W'(1)) begin
            q_bank_d  = ld_bank_q;
            ld_bank_d = !ld_bank_q;
            len_d     = n_q;
            pos_d     = '0;
            qovf_d    = block_ovf_q;
            state_d   = ST_EMIT;
          end else begin
            rounds_d = ROUNDS_W'(rounds_q - 1'b1);
            sum_d    = mode_q ? (sum_q - TEA_DELTA) : (sum_q + TEA_DELTA);
          end
        end
      end

      ST_EMIT: begin
        re      = 1'b1;
        raddr   = {q_bank_q, AW'(0)};
        state_d = ST_OUT;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_q       <= '{default: '0};
      mode_q      <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      n_q         <= '0;
      block_ovf_q <= 1'b0;
      ld_bank_q   <= 1'b0;
      q_bank_q    <= 1'b1;
      len_q       <= '0;
      pos_q       <= '0;
      qovf_q      <= 1'b0;
      rounds_q    <= '0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_q       <= key_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      n_q         <= n_d;
      block_ovf_q <= block_ovf_d;
      ld_bank_q   <= ld_bank_d;
      q_bank_q    <= q_bank_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      qovf_q      <= qovf_d;
      rounds_q    <= rounds_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    carry_q    <= carry_d;
    cur_q      <= cur_d;
    p_q        <= p_d;
    fwd_data_q <= fwd_data_d;
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  `XX_ASSERT_IMP(a_banks_apart, 1'b1, q_bank_q != ld_bank_q)
  `XX_ASSERT_NXT(a_emit_reads, state_q == ST_EMIT, state_q == ST_OUT)
  `XX_ASSERT_IMP(a_out_from_read, $rose(out_chan.valid), $past(state_q) == ST_OUT)
  `XX_ASSERT_IMP(a_run_rounds, state_q == ST_RUN, rounds_q != '0)

endmodule
